/* rtl/imupd_pkg.sv */
// imupd_pkg: shared codes, control word layout and microprogram rom for the imu packet deframer
// no dependencies; used by imu_packet_deframer_core
`default_nettype none

package imupd_pkg;

	// framing bytes
	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_SL    = 8'h73;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_NL    = 8'h6E;
	localparam logic [7:0] CH_G     = 8'h47;

	// packet geometry
	localparam int unsigned STORE_DEPTH = 86;
	localparam int unsigned ADDR_W      = 7;
	localparam logic [6:0]  SHORT_LAST  = 7'd50;
	localparam logic [6:0]  LONG_LAST   = 7'd85;
	localparam logic [6:0]  GPS_MARK_POS = 7'd33;

	// result codes
	localparam logic [4:0] END_ID        = 5'd27;
	localparam logic [2:0] STAT_IMU_OK   = 3'd0;
	localparam logic [2:0] STAT_GPS_OK   = 3'd1;
	localparam logic [2:0] STAT_NO_GPS   = 3'd2;
	localparam logic [2:0] STAT_CKS_ERR  = 3'd3;
	localparam logic [2:0] STAT_BAD_TYPE = 3'd4;

	// microprogram
	localparam int unsigned PC_W     = 6;
	localparam logic [5:0]  END_STEP = 6'd39;

	localparam logic [1:0] OP_FIELD = 2'd0;
	localparam logic [1:0] OP_JUMP  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [1:0] COND_NOT_S  = 2'd0;
	localparam logic [1:0] COND_NOT_N  = 2'd1;
	localparam logic [1:0] COND_NO_GPS = 2'd2;

	localparam logic [2:0] FMT_BE16S = 3'd0;
	localparam logic [2:0] FMT_BE16U = 3'd1;
	localparam logic [2:0] FMT_U8    = 3'd2;
	localparam logic [2:0] FMT_LE32S = 3'd3;
	localparam logic [2:0] FMT_LE32U = 3'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] cond;
		logic [2:0] fmt;
		logic [6:0] addr;
		logic [4:0] fid;
		logic [5:0] target;
	} ctl_word_t;

	// last byte counter value of a field read
	function automatic logic [1:0] last_cnt(input logic [2:0] fmt);
		logic [1:0] n;
		begin
			case (fmt)
				FMT_U8:    n = 2'd0;
				FMT_BE16S: n = 2'd1;
				FMT_BE16U: n = 2'd1;
				default:   n = 2'd3;
			endcase
			return n;
		end
	endfunction

	// program: sensors, servo block for 'S', servo block for 'N', gps block, end
	function automatic ctl_word_t rom_word(input logic [5:0] pc);
		ctl_word_t w;
		logic [5:0] k;
		begin
			w = '{op: OP_END, cond: COND_NOT_S, fmt: FMT_U8, addr: 7'd0,
				fid: END_ID, target: 6'd0};
			k = 6'd0;
			if (pc < 6'd9) begin
				w.op   = OP_FIELD;
				w.fmt  = FMT_BE16S;
				w.fid  = pc[4:0];
				w.addr = 7'd3 + {pc, 1'b0};
			end else if (pc == 6'd9) begin
				w.op   = OP_FIELD;
				w.fmt  = FMT_BE16S;
				w.fid  = 5'd9;
				w.addr = 7'd27;
			end else if (pc == 6'd10) begin
				w.op   = OP_FIELD;
				w.fmt  = FMT_BE16S;
				w.fid  = 5'd10;
				w.addr = 7'd29;
			end else if (pc == 6'd11) begin
				w.op     = OP_JUMP;
				w.cond   = COND_NOT_S;
				w.target = 6'd21;
			end else if (pc == 6'd12) begin
				w.op   = OP_FIELD;
				w.fmt  = FMT_U8;
				w.fid  = 5'd11;
				w.addr = 7'd32;
			end else if (pc < 6'd21) begin
				k      = pc - 6'd13;
				w.op   = OP_FIELD;
				w.fmt  = FMT_BE16U;
				w.fid  = 5'd12 + k[4:0];
				w.addr = 7'd33 + {k, 1'b0};
			end else if (pc == 6'd21) begin
				w.op     = OP_JUMP;
				w.cond   = COND_NOT_N;
				w.target = 6'd31;
			end else if (pc == 6'd22) begin
				w.op   = OP_FIELD;
				w.fmt  = FMT_U8;
				w.fid  = 5'd11;
				w.addr = 7'd67;
			end else if (pc < 6'd31) begin
				k      = pc - 6'd23;
				w.op   = OP_FIELD;
				w.fmt  = FMT_BE16U;
				w.fid  = 5'd12 + k[4:0];
				w.addr = 7'd68 + {k, 1'b0};
			end else if (pc == 6'd31) begin
				w.op     = OP_JUMP;
				w.cond   = COND_NO_GPS;
				w.target = END_STEP;
			end else if (pc < 6'd38) begin
				k      = pc - 6'd32;
				w.op   = OP_FIELD;
				w.fmt  = FMT_LE32S;
				w.fid  = 5'd20 + k[4:0];
				w.addr = 7'd34 + {k[4:0], 2'b00};
			end else if (pc == 6'd38) begin
				w.op   = OP_FIELD;
				w.fmt  = FMT_LE32U;
				w.fid  = 5'd26;
				w.addr = 7'd58;
			end
			return w;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/imu_packet_deframer_core.sv */
// imu_packet_deframer_core: byte-stream deframer for imu/gps packets, microcoded field emitter
// depends on imupd_pkg (codes, control word type, microprogram rom)
`default_nettype none

// usage
//   slave stream: one received serial byte per transfer (s_axis_tdata[7:0])
//   master stream: one field per transfer; tuser holds the field id, tdata the raw
//   value and status, tlast marks the status item that closes each run
//   while hunting and collecting, the block takes one byte per cycle
//   the byte that completes a packet (or an unknown type byte) starts the
//   microprogram; s_axis_tready stays low until the run has been handed to the
//   output register
//   field of n bytes: decode, n store reads, read wait and emit steps;
//   conditional jump and end item: decode step only; the run of a full long
//   upper-case packet with gps is paced by the single store read port
//   the first field reaches the output through decode, reads, wait and emit after
//   the completing byte, an end item alone (bad checksum or unknown type) straight from decode
//   a stalled receiver holds the output register and freezes the sequencer in
//   its emit or decode step; a loaded end item may wait while new bytes are taken
//   reset (arst_n low) returns to the header hunt with the sum cleared and
//   the output empty; the packet store needs no clearing
module imu_packet_deframer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [32:0] value, [35:33] status, [39:36] zero
	output logic [4:0]       m_axis_tuser,   // [4:0] field_id
	output logic             m_axis_tlast    // last
);

	// sequencer states
	localparam logic [2:0] ST_HUNT = 3'd0;   // header hunt and packet collection
	localparam logic [2:0] ST_EXEC = 3'd1;   // decode control word
	localparam logic [2:0] ST_READ = 3'd2;   // issue store reads
	localparam logic [2:0] ST_WAIT = 3'd3;   // last read data returns
	localparam logic [2:0] ST_EMIT = 3'd4;   // hand field to output register

	logic [2:0]  state_q;
	logic [1:0]  hdr_cnt_q;
	logic [6:0]  byte_idx_q;
	logic [15:0] sum_q;
	logic [7:0]  type_q;
	logic [7:0]  cks_hi_q;
	logic        mark_q;
	logic        gps_q;
	logic [2:0]  stat_q;
	logic [imupd_pkg::PC_W-1:0] pc_q;
	logic [1:0]  cnt_q;
	logic        rd_vld_q;
	logic [7:0]  rd_data_q;
	logic [31:0] acc_q;

	// packet store, read data registered
	logic [7:0]  mem [imupd_pkg::STORE_DEPTH];

	// output register
	logic        out_valid_q;
	logic [4:0]  out_fid_q;
	logic [32:0] out_val_q;
	logic [2:0]  out_stat_q;
	logic        out_last_q;

	imupd_pkg::ctl_word_t word;
	logic        in_xfer;
	logic        slot_free;
	logic        is_long;
	logic        known_type;
	logic [6:0]  len_m1;
	logic [6:0]  len_m2;
	logic [6:0]  rd_addr;
	logic        jump_take;
	logic        load_field;
	logic        load_end;
	logic [32:0] field_val;
	logic [7:0]  rx_byte;

	assign rx_byte       = s_axis_tdata;
	assign s_axis_tready = (state_q == ST_HUNT);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign slot_free     = ~out_valid_q | m_axis_tready;

	// control word of the current step
	assign word    = imupd_pkg::rom_word(pc_q);
	assign rd_addr = word.addr + {5'd0, cnt_q};

	assign is_long    = (type_q == imupd_pkg::CH_N) || (type_q == imupd_pkg::CH_NL);
	assign len_m1     = is_long ? imupd_pkg::LONG_LAST : imupd_pkg::SHORT_LAST;
	assign len_m2     = len_m1 - 7'd1;
	assign known_type = (rx_byte == imupd_pkg::CH_S) || (rx_byte == imupd_pkg::CH_SL) ||
		(rx_byte == imupd_pkg::CH_N) || (rx_byte == imupd_pkg::CH_NL);

	// jump conditions
	always_comb begin
		case (word.cond)
			imupd_pkg::COND_NOT_S:  jump_take = (type_q != imupd_pkg::CH_S);
			imupd_pkg::COND_NOT_N:  jump_take = (type_q != imupd_pkg::CH_N);
			imupd_pkg::COND_NO_GPS: jump_take = ~gps_q;
			default:                jump_take = 1'b1;
		endcase
	end

	// raw value formatting from the byte accumulator
	always_comb begin
		case (word.fmt)
			imupd_pkg::FMT_BE16S: field_val = {{17{acc_q[15]}}, acc_q[15:0]};
			imupd_pkg::FMT_BE16U: field_val = {17'd0, acc_q[15:0]};
			imupd_pkg::FMT_U8:    field_val = {25'd0, acc_q[7:0]};
			imupd_pkg::FMT_LE32S: field_val = {acc_q[31], acc_q};
			default:              field_val = {1'b0, acc_q};
		endcase
	end

	assign load_field = (state_q == ST_EMIT) & slot_free;
	assign load_end   = (state_q == ST_EXEC) & (word.op == imupd_pkg::OP_END) & slot_free;

	// collection and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_HUNT;
			hdr_cnt_q  <= 2'd0;
			byte_idx_q <= 7'd0;
			sum_q      <= 16'd0;
			type_q     <= 8'd0;
			cks_hi_q   <= 8'd0;
			mark_q     <= 1'b0;
			gps_q      <= 1'b0;
			stat_q     <= imupd_pkg::STAT_IMU_OK;
			pc_q       <= '0;
			cnt_q      <= 2'd0;
			rd_vld_q   <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == ST_READ);
			case (state_q)
				ST_HUNT: begin
					if (in_xfer) begin
						if (byte_idx_q == 7'd0) begin
							if (hdr_cnt_q != 2'd2) begin
								// header hunt: any other byte starts over
								hdr_cnt_q <= (rx_byte == imupd_pkg::HDR_BYTE) ?
									hdr_cnt_q + 2'd1 : 2'd0;
							end else begin
								// type byte, even a third 0x55
								type_q    <= rx_byte;
								hdr_cnt_q <= 2'd0;
								if (known_type) begin
									sum_q      <= {8'd0, rx_byte};
									byte_idx_q <= 7'd3;
								end else begin
									stat_q  <= imupd_pkg::STAT_BAD_TYPE;
									pc_q    <= imupd_pkg::END_STEP;
									state_q <= ST_EXEC;
								end
							end
						end else begin
							if (byte_idx_q < len_m2)
								sum_q <= sum_q + {8'd0, rx_byte};
							if (byte_idx_q == len_m2)
								cks_hi_q <= rx_byte;
							if (byte_idx_q == imupd_pkg::GPS_MARK_POS)
								mark_q <= (rx_byte == imupd_pkg::CH_G);
							if (byte_idx_q == len_m1) begin
								// packet complete: check sum and pick the entry step
								byte_idx_q <= 7'd0;
								sum_q      <= 16'd0;
								state_q    <= ST_EXEC;
								gps_q      <= is_long & mark_q;
								if ({cks_hi_q, rx_byte} != sum_q) begin
									stat_q <= imupd_pkg::STAT_CKS_ERR;
									pc_q   <= imupd_pkg::END_STEP;
								end else begin
									pc_q <= '0;
									if (!is_long)
										stat_q <= imupd_pkg::STAT_IMU_OK;
									else if (mark_q)
										stat_q <= imupd_pkg::STAT_GPS_OK;
									else
										stat_q <= imupd_pkg::STAT_NO_GPS;
								end
							end else begin
								byte_idx_q <= byte_idx_q + 7'd1;
							end
						end
					end
				end
				ST_EXEC: begin
					case (word.op)
						imupd_pkg::OP_FIELD: begin
							cnt_q   <= 2'd0;
							state_q <= ST_READ;
						end
						imupd_pkg::OP_JUMP: begin
							pc_q <= jump_take ? word.target : pc_q + 6'd1;
						end
						imupd_pkg::OP_END: begin
							if (slot_free)
								state_q <= ST_HUNT;
						end
						default: begin
							state_q <= ST_HUNT;
						end
					endcase
				end
				ST_READ: begin
					if (cnt_q == imupd_pkg::last_cnt(word.fmt))
						state_q <= ST_WAIT;
					else
						cnt_q <= cnt_q + 2'd1;
				end
				ST_WAIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						pc_q    <= pc_q + 6'd1;
						state_q <= ST_EXEC;
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	// packet store: write on collected bytes, one registered read port
	always_ff @(posedge clk) begin
		if (in_xfer && (byte_idx_q != 7'd0))
			mem[byte_idx_q] <= rx_byte;
		rd_data_q <= mem[rd_addr];
	end

	// byte accumulator: little-endian fields shift in from the top
	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			if ((word.fmt == imupd_pkg::FMT_LE32S) || (word.fmt == imupd_pkg::FMT_LE32U))
				acc_q <= {rd_data_q, acc_q[31:8]};
			else
				acc_q <= {acc_q[23:0], rd_data_q};
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_field || load_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_field) begin
			out_fid_q  <= word.fid;
			out_val_q  <= field_val;
			out_stat_q <= stat_q;
			out_last_q <= 1'b0;
		end else if (load_end) begin
			out_fid_q  <= imupd_pkg::END_ID;
			out_val_q  <= 33'd0;
			out_stat_q <= stat_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_stat_q, out_val_q};
	assign m_axis_tuser  = out_fid_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// program counter stays inside the microprogram
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= imupd_pkg::END_STEP)
		else $error("pc beyond end step");

	// store index is idle or within a packet body
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_idx_q == 7'd0) || ((byte_idx_q >= 7'd3) && (byte_idx_q <= imupd_pkg::LONG_LAST)))
		else $error("byte index out of range");

	// collection state is cleared whenever the sequencer runs
	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_HUNT) |-> ((byte_idx_q == 7'd0) && (hdr_cnt_q == 2'd0) && (sum_q == 16'd0)))
		else $error("collection state not cleared during emission");

	// end item carries the end id and a zero value
	a_end_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
			((m_axis_tuser == imupd_pkg::END_ID) && (m_axis_tdata[32:0] == 33'd0)))
		else $error("malformed end item");
`endif

endmodule

`default_nettype wire
